// ===== rtl/core/wmvs_pkg.sv =====
// Package: shared types and constants of the wedge-masked voxel statistics block.
package wmvs_pkg;

  localparam int COORD_BITS    = 10;
  localparam int VALUE_BITS    = 16;
  localparam int CTR_BITS      = COORD_BITS + 1;
  localparam int SCALE_BITS    = 16;
  localparam int TAN_BITS      = 25;
  localparam int TAN_FRAC      = 16;
  localparam int CNT_BITS      = 31;
  localparam int SUM_BITS      = VALUE_BITS + 30;
  localparam int DIFF_BITS     = COORD_BITS + 2;
  localparam int MAG_BITS      = DIFF_BITS - 1 + SCALE_BITS;
  localparam int MUL_A_BITS    = TAN_BITS;
  localparam int MUL_B_BITS    = MAG_BITS + 1;
  localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = TAN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Y     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE_Z     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAN_LOW     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TAN_HIGH    = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT_MODE = 3'd6;

  localparam logic [CTR_BITS-1:0]          CENTER_RST   = 11'd1024;
  localparam logic [SCALE_BITS-1:0]        SCALE_RST    = 16'd4096;
  localparam logic signed [TAN_BITS-1:0]   TAN_LOW_RST  = -25'sd65536;
  localparam logic signed [TAN_BITS-1:0]   TAN_HIGH_RST = 25'sd65536;

  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [SUM_BITS-1:0] QUOT_POS_MAX = SUM_BITS'(2**(VALUE_BITS-1) - 1);
  localparam logic [SUM_BITS-1:0] QUOT_NEG_MAX = SUM_BITS'(2**(VALUE_BITS-1));

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] voxel_value;
    logic [COORD_BITS-1:0]        y_index;
    logic [COORD_BITS-1:0]        z_index;
    logic                         is_last;
  } wmvs_in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]          voxel_count;
    logic signed [VALUE_BITS-1:0] min_value;
    logic signed [VALUE_BITS-1:0] max_value;
    logic signed [VALUE_BITS-1:0] mean_value;
  } wmvs_out_t;

  typedef struct packed {
    logic [CTR_BITS-1:0]        center_y;
    logic [CTR_BITS-1:0]        center_z;
    logic [SCALE_BITS-1:0]      scale_y;
    logic [SCALE_BITS-1:0]      scale_z;
    logic signed [TAN_BITS-1:0] tan_low;
    logic signed [TAN_BITS-1:0] tan_high;
    logic                       invert_mode;
  } wmvs_cfg_t;

  typedef struct packed {
    logic done;
    logic pass;
  } wmvs_wedge_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT
  } wmvs_state_e;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_MUL_Y,
    WS_MUL_Z,
    WS_MUL_LO,
    WS_MUL_HI,
    WS_DECIDE
  } wmvs_wedge_state_e;

endpackage

// ===== rtl/core/wmvs_wedge.sv =====
// Wedge test: sequencer around one shared signed multiplier.
module wmvs_wedge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [wmvs_pkg::COORD_BITS-1:0]     y_index_i,
  input  logic [wmvs_pkg::COORD_BITS-1:0]     z_index_i,
  input  wmvs_pkg::wmvs_cfg_t                 cfg_i,
  output wmvs_pkg::wmvs_wedge_res_t           res_o
);

  wmvs_pkg::wmvs_wedge_state_e state_q, state_d;

  logic signed [wmvs_pkg::DIFF_BITS-1:0]  dy_q, dz_q;
  logic signed [wmvs_pkg::PROD_BITS-1:0]  prod_q;
  logic [wmvs_pkg::MAG_BITS-1:0]          a_q, b_q;
  logic                                   ge_lo_q;

  logic signed [wmvs_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [wmvs_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [wmvs_pkg::PROD_BITS-1:0]  prod;
  logic signed [wmvs_pkg::MUL_B_BITS-1:0] mag_src, mag_abs;
  logic [wmvs_pkg::MAG_BITS-1:0]          mag;
  logic signed [wmvs_pkg::PROD_BITS-1:0]  lhs;
  logic                                   le_hi, a_zero, b_zero;

  always_comb begin
    unique case (state_q)
      wmvs_pkg::WS_MUL_Z: begin
        mul_a = wmvs_pkg::MUL_A_BITS'(dz_q);
        mul_b = wmvs_pkg::MUL_B_BITS'(cfg_i.scale_z);
      end
      wmvs_pkg::WS_MUL_LO: begin
        mul_a = cfg_i.tan_low;
        mul_b = wmvs_pkg::MUL_B_BITS'(a_q);
      end
      wmvs_pkg::WS_MUL_HI: begin
        mul_a = cfg_i.tan_high;
        mul_b = wmvs_pkg::MUL_B_BITS'(a_q);
      end
      default: begin
        mul_a = wmvs_pkg::MUL_A_BITS'(dy_q);
        mul_b = wmvs_pkg::MUL_B_BITS'(cfg_i.scale_y);
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign mag_src = $signed(prod_q[wmvs_pkg::MUL_B_BITS-1:0]);
  assign mag_abs = mag_src[wmvs_pkg::MUL_B_BITS-1] ? -mag_src : mag_src;
  assign mag     = mag_abs[wmvs_pkg::MAG_BITS-1:0];
  assign lhs     = wmvs_pkg::PROD_BITS'({b_q, {wmvs_pkg::TAN_FRAC{1'b0}}});
  assign le_hi   = lhs <= prod_q;
  assign a_zero  = a_q == '0;
  assign b_zero  = b_q == '0;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      wmvs_pkg::WS_IDLE: begin
        if (start_i) begin
          dy_q <= wmvs_pkg::DIFF_BITS'({1'b0, y_index_i, 1'b0})
                - wmvs_pkg::DIFF_BITS'({1'b0, cfg_i.center_y});
          dz_q <= wmvs_pkg::DIFF_BITS'({1'b0, z_index_i, 1'b0})
                - wmvs_pkg::DIFF_BITS'({1'b0, cfg_i.center_z});
        end
      end
      wmvs_pkg::WS_MUL_Y: prod_q <= prod;
      wmvs_pkg::WS_MUL_Z: begin
        a_q    <= mag;
        prod_q <= prod;
      end
      wmvs_pkg::WS_MUL_LO: begin
        b_q    <= mag;
        prod_q <= prod;
      end
      wmvs_pkg::WS_MUL_HI: begin
        ge_lo_q <= lhs >= prod_q;
        prod_q  <= prod;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmvs_pkg::WS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      wmvs_pkg::WS_IDLE:
        state_d = start_i ? wmvs_pkg::WS_MUL_Y : wmvs_pkg::WS_IDLE;
      wmvs_pkg::WS_MUL_Y:  state_d = wmvs_pkg::WS_MUL_Z;
      wmvs_pkg::WS_MUL_Z:  state_d = wmvs_pkg::WS_MUL_LO;
      wmvs_pkg::WS_MUL_LO: state_d = wmvs_pkg::WS_MUL_HI;
      wmvs_pkg::WS_MUL_HI: state_d = wmvs_pkg::WS_DECIDE;
      default:             state_d = wmvs_pkg::WS_IDLE;
    endcase
  end

  always_comb begin
    res_o.done = state_q == wmvs_pkg::WS_DECIDE;
    if (cfg_i.invert_mode) begin
      res_o.pass = a_zero ? b_zero : (ge_lo_q && le_hi);
    end else begin
      res_o.pass = a_zero ? !b_zero : (!ge_lo_q || !le_hi);
    end
  end

endmodule

// ===== rtl/core/wmvs_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module wmvs_divider (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [wmvs_pkg::SUM_BITS-1:0]     dividend_i,
  input  logic [wmvs_pkg::CNT_BITS-1:0]     divisor_i,
  output logic                              done_o,
  output logic [wmvs_pkg::SUM_BITS-1:0]     quot_o
);

  localparam int ITER_BITS = $clog2(wmvs_pkg::SUM_BITS);

  logic                               busy_q;
  logic [ITER_BITS-1:0]               cnt_q;
  logic [wmvs_pkg::SUM_BITS-1:0]      qd_q;
  logic [wmvs_pkg::CNT_BITS-1:0]      rem_q, dvs_q;
  logic [wmvs_pkg::CNT_BITS:0]        rem_sh, rem_sub;
  logic                               fits;

  assign rem_sh  = {rem_q, qd_q[wmvs_pkg::SUM_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign done_o  = busy_q && (cnt_q == ITER_BITS'(wmvs_pkg::SUM_BITS - 1));
  assign quot_o  = qd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      qd_q  <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      qd_q  <= {qd_q[wmvs_pkg::SUM_BITS-2:0], fits};
      rem_q <= fits ? rem_sub[wmvs_pkg::CNT_BITS-1:0] : rem_sh[wmvs_pkg::CNT_BITS-1:0];
    end
  end

endmodule

// ===== rtl/core/wedge_masked_voxel_stats_unit.sv =====
// Top level: wedge-masked voxel statistics with config registers and output register.
// Each request stalls the input from acceptance through 4 multiplies on the shared multiplier,
// a decide step and a return to idle; a request marked last also holds it through
// the bit-serial division of the sum by the count and until its result is taken
// into the output register.
// Reset restores the register defaults, clears count and sum and sets min and max to VAL_MAX and VAL_MIN.
module wedge_masked_voxel_stats_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  wmvs_pkg::wmvs_in_t                    in_req_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output wmvs_pkg::wmvs_out_t                   out_res_o,
  input  logic                                  cfg_we_i,
  input  logic [wmvs_pkg::CFG_IDX_BITS-1:0]     cfg_idx_i,
  input  logic [wmvs_pkg::CFG_DATA_BITS-1:0]    cfg_data_i
);

  wmvs_pkg::wmvs_state_e      state_q, state_d;
  wmvs_pkg::wmvs_cfg_t        cfg_q;
  wmvs_pkg::wmvs_wedge_res_t  wedge_res;
  wmvs_pkg::wmvs_out_t        out_q, out_d;

  logic signed [wmvs_pkg::VALUE_BITS-1:0] v_q, min_q, max_q, mean;
  logic [wmvs_pkg::SUM_BITS-1:0]          sum_q, sum_mag, quot;
  logic [wmvs_pkg::CNT_BITS-1:0]          count_q;
  logic                                   last_q, neg_q, out_valid_q;
  logic                                   accept, div_start, div_done, emit;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign sum_mag     = sum_q[wmvs_pkg::SUM_BITS-1] ? -sum_q : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_y    <= wmvs_pkg::CENTER_RST;
      cfg_q.center_z    <= wmvs_pkg::CENTER_RST;
      cfg_q.scale_y     <= wmvs_pkg::SCALE_RST;
      cfg_q.scale_z     <= wmvs_pkg::SCALE_RST;
      cfg_q.tan_low     <= wmvs_pkg::TAN_LOW_RST;
      cfg_q.tan_high    <= wmvs_pkg::TAN_HIGH_RST;
      cfg_q.invert_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wmvs_pkg::CFG_CENTER_Y:
          cfg_q.center_y <= cfg_data_i[wmvs_pkg::CTR_BITS-1:0];
        wmvs_pkg::CFG_CENTER_Z:
          cfg_q.center_z <= cfg_data_i[wmvs_pkg::CTR_BITS-1:0];
        wmvs_pkg::CFG_SCALE_Y:
          cfg_q.scale_y <= cfg_data_i[wmvs_pkg::SCALE_BITS-1:0];
        wmvs_pkg::CFG_SCALE_Z:
          cfg_q.scale_z <= cfg_data_i[wmvs_pkg::SCALE_BITS-1:0];
        wmvs_pkg::CFG_TAN_LOW:     cfg_q.tan_low <= $signed(cfg_data_i);
        wmvs_pkg::CFG_TAN_HIGH:    cfg_q.tan_high <= $signed(cfg_data_i);
        wmvs_pkg::CFG_INVERT_MODE: cfg_q.invert_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  wmvs_wedge u_wedge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .y_index_i (in_req_i.y_index),
    .z_index_i (in_req_i.z_index),
    .cfg_i     (cfg_q),
    .res_o     (wedge_res)
  );

  wmvs_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_mag),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      v_q    <= in_req_i.voxel_value;
      last_q <= in_req_i.is_last;
    end
    if (div_start) begin
      neg_q <= sum_q[wmvs_pkg::SUM_BITS-1];
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  // running statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= wmvs_pkg::VAL_MAX;
      max_q   <= wmvs_pkg::VAL_MIN;
      sum_q   <= '0;
      count_q <= '0;
    end else if (emit) begin
      min_q   <= wmvs_pkg::VAL_MAX;
      max_q   <= wmvs_pkg::VAL_MIN;
      sum_q   <= '0;
      count_q <= '0;
    end else if (state_q == wmvs_pkg::ST_TEST && wedge_res.done && wedge_res.pass) begin
      if (v_q < min_q) min_q <= v_q;
      if (v_q > max_q) max_q <= v_q;
      sum_q <= sum_q + wmvs_pkg::SUM_BITS'(v_q);
      if (count_q != '1) count_q <= count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    if (count_q == '0) begin
      mean = '0;
    end else if (!neg_q) begin
      mean = (quot > wmvs_pkg::QUOT_POS_MAX) ? wmvs_pkg::VAL_MAX
                                             : $signed(quot[wmvs_pkg::VALUE_BITS-1:0]);
    end else begin
      mean = (quot > wmvs_pkg::QUOT_NEG_MAX) ? wmvs_pkg::VAL_MIN
                                             : -$signed(quot[wmvs_pkg::VALUE_BITS-1:0]);
    end
    out_d.voxel_count = count_q;
    out_d.min_value   = min_q;
    out_d.max_value   = max_q;
    out_d.mean_value  = mean;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wmvs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    unique case (state_q)
      wmvs_pkg::ST_IDLE:
        state_d = accept ? wmvs_pkg::ST_TEST : wmvs_pkg::ST_IDLE;
      wmvs_pkg::ST_TEST: begin
        if (!wedge_res.done) begin
          state_d = wmvs_pkg::ST_TEST;
        end else begin
          state_d = last_q ? wmvs_pkg::ST_DIV_START : wmvs_pkg::ST_IDLE;
        end
      end
      wmvs_pkg::ST_DIV_START: state_d = wmvs_pkg::ST_DIV_WAIT;
      wmvs_pkg::ST_DIV_WAIT:
        state_d = div_done ? wmvs_pkg::ST_EMIT : wmvs_pkg::ST_DIV_WAIT;
      wmvs_pkg::ST_EMIT:
        state_d = emit ? wmvs_pkg::ST_IDLE : wmvs_pkg::ST_EMIT;
      default: state_d = wmvs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != wmvs_pkg::ST_IDLE;
    div_start  = state_q == wmvs_pkg::ST_DIV_START;
    emit       = (state_q == wmvs_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);
  end

endmodule

// ===== dv/wedge_masked_voxel_stats_unit_tb.sv =====
// Testbench for wedge_masked_voxel_stats_unit: directed and random voxel streams checked per volume.
module wedge_masked_voxel_stats_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wmvs_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int SECTION_ITEMS = 60;
  localparam int MAX_REPORTS   = 10;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  wmvs_in_t                 in_req_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  wmvs_out_t                out_res_o;
  logic                     cfg_we_i    = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data_i  = '0;

  // register copies and running statistics of the predictor
  logic [CTR_BITS-1:0]        ctr_y    = CENTER_RST;
  logic [CTR_BITS-1:0]        ctr_z    = CENTER_RST;
  logic [SCALE_BITS-1:0]      scl_y    = SCALE_RST;
  logic [SCALE_BITS-1:0]      scl_z    = SCALE_RST;
  logic signed [TAN_BITS-1:0] tan_lo   = TAN_LOW_RST;
  logic signed [TAN_BITS-1:0] tan_hi   = TAN_HIGH_RST;
  logic                       inv_mode = 1'b0;
  longint                     acc_min  = VAL_MAX;
  longint                     acc_max  = VAL_MIN;
  logic [SUM_BITS-1:0]        acc_sum  = '0;
  logic [CNT_BITS-1:0]        acc_cnt  = '0;

  wmvs_in_t    voxels_pending[$];
  wmvs_out_t   stats_due[$];
  int unsigned n_queued       = 0;
  int unsigned n_accepted     = 0;
  int unsigned err_cnt        = 0;
  int unsigned send_idle_pct  = 20;
  int unsigned recv_stall_pct = 46;
  int unsigned hold_left      = 0;

  wedge_masked_voxel_stats_unit dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .in_req_i,
    .out_valid_o,
    .out_stall_i,
    .out_res_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint axis_mag(logic [COORD_BITS-1:0] idx, logic [CTR_BITS-1:0] ctr,
                                      logic [SCALE_BITS-1:0] scl);
    longint p;
    p = (2 * longint'(idx) - longint'(ctr)) * longint'(scl);
    return (p < 0) ? -p : p;
  endfunction

  // b/a against the tangents, cross-multiplied
  function automatic bit wedge_counts(longint a, longint b);
    longint lhs, lo, hi;
    lhs = b * (longint'(1) << TAN_FRAC);
    lo  = longint'(tan_lo) * a;
    hi  = longint'(tan_hi) * a;
    if (inv_mode) begin
      if (a == 0) return b == 0;
      return lhs >= lo && lhs <= hi;
    end
    if (a == 0) return b != 0;
    return lhs < lo || lhs > hi;
  endfunction

  function automatic void fold_voxel(wmvs_in_t vx);
    longint    v, mean;
    wmvs_out_t r;
    v = longint'($signed(vx.voxel_value));
    if (wedge_counts(axis_mag(vx.y_index, ctr_y, scl_y), axis_mag(vx.z_index, ctr_z, scl_z))) begin
      if (v < acc_min) acc_min = v;
      if (v > acc_max) acc_max = v;
      acc_sum = acc_sum + SUM_BITS'(v);
      if (acc_cnt != '1) acc_cnt = acc_cnt + 1'b1;
    end
    if (vx.is_last) begin
      mean = 0;
      if (acc_cnt != 0) begin
        mean = longint'($signed(acc_sum)) / longint'(acc_cnt);
        if (mean > VAL_MAX) mean = VAL_MAX;
        if (mean < VAL_MIN) mean = VAL_MIN;
      end
      r.voxel_count = acc_cnt;
      r.min_value   = acc_min[VALUE_BITS-1:0];
      r.max_value   = acc_max[VALUE_BITS-1:0];
      r.mean_value  = mean[VALUE_BITS-1:0];
      stats_due.push_back(r);
      acc_min = VAL_MAX;
      acc_max = VAL_MIN;
      acc_sum = '0;
      acc_cnt = '0;
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      fold_voxel(in_req_i);
      n_accepted++;
    end
    if (!in_valid_i || !in_stall_o) begin
      if (rst_ni && voxels_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_req_i   <= voxels_pending.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    wmvs_out_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_due.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result count %0d min %0d max %0d mean %0d", $time,
                   out_res_o.voxel_count, $signed(out_res_o.min_value),
                   $signed(out_res_o.max_value), $signed(out_res_o.mean_value));
      end else begin
        due = stats_due.pop_front();
        if (out_res_o.voxel_count !== due.voxel_count || out_res_o.min_value !== due.min_value ||
            out_res_o.max_value !== due.max_value || out_res_o.mean_value !== due.mean_value) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: mismatch exp count %0d min %0d max %0d mean %0d, got %0d %0d %0d %0d",
                     $time, due.voxel_count, $signed(due.min_value), $signed(due.max_value),
                     $signed(due.mean_value), out_res_o.voxel_count,
                     $signed(out_res_o.min_value), $signed(out_res_o.max_value),
                     $signed(out_res_o.mean_value));
        end
      end
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  function automatic void queue_voxel(logic [VALUE_BITS-1:0] v, logic [COORD_BITS-1:0] y,
                                      logic [COORD_BITS-1:0] z, bit last);
    wmvs_in_t vx;
    vx.voxel_value = v;
    vx.y_index     = y;
    vx.z_index     = z;
    vx.is_last     = last;
    voxels_pending.push_back(vx);
    n_queued++;
  endfunction

  function automatic logic [COORD_BITS-1:0] pick_coord(logic [CTR_BITS-1:0] ctr);
    case ($urandom_range(7))
      0:       return ctr[CTR_BITS-1:1];
      1:       return '0;
      2:       return '1;
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(7))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2, 3:    return VALUE_BITS'($urandom_range(200)) - 100;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  function automatic void queue_volume(int unsigned max_len);
    int unsigned len;
    len = $urandom_range(max_len, 1);
    for (int unsigned i = 1; i <= len; i++)
      queue_voxel(pick_value(), pick_coord(ctr_y), pick_coord(ctr_z), i == len);
  endfunction

  // random bits above the register width
  function automatic logic [CFG_DATA_BITS-1:0] pad_junk(int unsigned v, int unsigned w);
    logic [CFG_DATA_BITS-1:0] m;
    m = (CFG_DATA_BITS'(1) << w) - 1'b1;
    return (CFG_DATA_BITS'($urandom) & ~m) | (CFG_DATA_BITS'(v) & m);
  endfunction

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_CENTER_Y:    ctr_y    = val[CTR_BITS-1:0];
      CFG_CENTER_Z:    ctr_z    = val[CTR_BITS-1:0];
      CFG_SCALE_Y:     scl_y    = val[SCALE_BITS-1:0];
      CFG_SCALE_Z:     scl_z    = val[SCALE_BITS-1:0];
      CFG_TAN_LOW:     tan_lo   = val[TAN_BITS-1:0];
      CFG_TAN_HIGH:    tan_hi   = val[TAN_BITS-1:0];
      CFG_INVERT_MODE: inv_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic load_setting(int cy, int cz, int sy, int sz, int tl, int th, bit inv);
    write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
    write_reg(CFG_CENTER_Y, pad_junk(cy, CTR_BITS));
    write_reg(CFG_CENTER_Z, pad_junk(cz, CTR_BITS));
    write_reg(CFG_SCALE_Y, pad_junk(sy, SCALE_BITS));
    write_reg(CFG_SCALE_Z, pad_junk(sz, SCALE_BITS));
    write_reg(CFG_TAN_LOW, pad_junk(tl, TAN_BITS));
    write_reg(CFG_TAN_HIGH, pad_junk(th, TAN_BITS));
    write_reg(CFG_INVERT_MODE, pad_junk(inv, 1));
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_random_setting(bit wild);
    int t1, t2, tmp;
    if (wild) begin
      load_setting($urandom_range(2047), $urandom_range(2047), $urandom_range(65535),
                   $urandom_range(65535), $urandom, $urandom, $urandom_range(1));
    end else begin
      t1 = $urandom_range(8 * 65536) - 4 * 65536;
      t2 = $urandom_range(8 * 65536) - 4 * 65536;
      if (t1 > t2) begin
        tmp = t1;
        t1  = t2;
        t2  = tmp;
      end
      load_setting($urandom_range(2047), $urandom_range(2047), $urandom_range(8192, 1024),
                   $urandom_range(8192, 1024), t1, t2, $urandom_range(1));
    end
  endtask

  // all requests taken, all results back, then let a volume-less item finish
  task automatic settle();
    while (n_accepted != n_queued || stats_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned stop_at;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: center on the axis, tangents +-1, outside of the wedge counts
    queue_voxel(100, 512, 512, 0);       // on the axis: not counted
    queue_voxel(32767, 512, 0, 0);       // a zero, b nonzero
    queue_voxel(-32768, 0, 512, 0);      // b zero: inside
    queue_voxel(-32768, 1023, 1023, 0);  // on the upper edge
    queue_voxel(-32768, 700, 1023, 0);   // steep: outside
    queue_voxel(5, 0, 1023, 1);
    queue_voxel(77, 512, 512, 1);        // empty volume
    queue_voxel(-7, 512, 100, 0);
    queue_voxel(-2, 512, 900, 1);        // negative mean truncates toward zero
    settle();

    load_setting(1024, 1024, 4096, 4096, -65536, 65536, 1);
    queue_voxel(-32768, 512, 512, 0);    // axis counts when inverted
    queue_voxel(32767, 512, 0, 0);
    queue_voxel(9, 1023, 1023, 0);       // edge counts when inverted
    queue_voxel(-3, 0, 512, 0);
    queue_voxel(11, 700, 1023, 0);
    queue_voxel(1, 600, 0, 1);
    settle();

    for (int s = 0; s < 9; s++) begin
      if (s == 3) begin
        send_idle_pct  = 46;
        recv_stall_pct = 20;
      end
      if (s == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (s)
        1:       load_setting(0, 2047, 65535, 65535, -16777216, 16777215, 0);
        2:       load_setting(2047, 0, 65535, 0, -16777216, 16777215, 1);
        3:       load_setting(1024, 1024, 0, 4096, -65536, 65536, 0);
        4:       load_setting(1024, 1024, 4096, 4096, 131072, -131072, 1);
        5:       load_setting($urandom_range(2047), 1024, 4096, 8192, 131072, -131072, 0);
        8:       load_random_setting(1'b1);
        default: load_random_setting(1'b0);
      endcase
      if (s == 7) hold_left <= HOLD_CYCLES;
      stop_at = n_queued + SECTION_ITEMS;
      while (n_queued < stop_at) queue_volume((s == 7) ? 2 : 12);
      settle();
    end

    if (err_cnt == 0 && stats_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== wedge_masked_voxel_stats_unit.f =====
rtl/core/wmvs_pkg.sv
rtl/core/wmvs_wedge.sv
rtl/core/wmvs_divider.sv
rtl/core/wedge_masked_voxel_stats_unit.sv
dv/wedge_masked_voxel_stats_unit_tb.sv
